// File: rtl/core/dftd_pkg.sv
package dftd_pkg;

  localparam int unsigned DefColumns = 26;
  localparam int unsigned DefRows    = 9;

  localparam logic [7:0] FrameMarker = 8'd50;

  localparam int unsigned RowBitsW  = 26;
  localparam int unsigned RowIndexW = 4;

  localparam int unsigned CmdDepth = 2;

  typedef enum logic {
    CMD_TOGGLE,
    CMD_FRAME
  } cmd_kind_e;

  // col/row carry the raw stream bytes; the back end slices them to the grid
  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] col;
    logic [7:0] row;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_DUMP
  } back_state_e;

endpackage

// File: rtl/core/dftd_front.sv
module dftd_front #(
  parameter int unsigned COLUMNS = dftd_pkg::DefColumns,
  parameter int unsigned ROWS    = dftd_pkg::DefRows
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_take_i,
  input  logic [7:0]    data_byte_i,
  output logic          cmd_push_o,
  output dftd_pkg::cmd_t cmd_o
);

  logic       expect_row_q, expect_row_d;
  logic [7:0] pend_col_q, pend_col_d;
  logic       in_grid;

  assign in_grid = ({1'b0, pend_col_q} < 9'(COLUMNS)) && ({1'b0, data_byte_i} < 9'(ROWS));

  always_comb begin
    expect_row_d = expect_row_q;
    pend_col_d   = pend_col_q;
    cmd_push_o   = 1'b0;
    cmd_o.kind   = dftd_pkg::CMD_TOGGLE;
    cmd_o.col    = pend_col_q;
    cmd_o.row    = data_byte_i;
    if (in_take_i) begin
      if (expect_row_q) begin
        expect_row_d = 1'b0;
        cmd_push_o   = in_grid;
      end else if (data_byte_i == dftd_pkg::FrameMarker) begin
        cmd_push_o = 1'b1;
        cmd_o.kind = dftd_pkg::CMD_FRAME;
      end else begin
        pend_col_d   = data_byte_i;
        expect_row_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_row_q <= 1'b0;
      pend_col_q   <= 8'd0;
    end else begin
      expect_row_q <= expect_row_d;
      pend_col_q   <= pend_col_d;
    end
  end

endmodule

// File: rtl/core/dftd_cmd_fifo.sv
module dftd_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dftd_pkg::cmd_t wdata_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output dftd_pkg::cmd_t rdata_o
);

  localparam int unsigned PtrW = (dftd_pkg::CmdDepth > 1) ? $clog2(dftd_pkg::CmdDepth) : 1;
  localparam int unsigned CntW = $clog2(dftd_pkg::CmdDepth + 1);

  dftd_pkg::cmd_t mem_q [dftd_pkg::CmdDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(dftd_pkg::CmdDepth));
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(dftd_pkg::CmdDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(dftd_pkg::CmdDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/dftd_back.sv
module dftd_back #(
  parameter int unsigned COLUMNS = dftd_pkg::DefColumns,
  parameter int unsigned ROWS    = dftd_pkg::DefRows
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cmd_valid_i,
  input  dftd_pkg::cmd_t                   cmd_i,
  output logic                             cmd_pop_o,
  output logic                             empty_o,
  input  logic                             pop_i,
  output logic [dftd_pkg::RowIndexW-1:0]   row_index_o,
  output logic [dftd_pkg::RowBitsW-1:0]    row_bits_o,
  output logic                             frame_last_o
);

  localparam int unsigned RowW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned ColW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  dftd_pkg::back_state_e state_q, state_d;
  logic [COLUMNS-1:0] cells_q [ROWS];
  logic [RowW-1:0]    row_q, row_d;
  logic               load, toggle, last_row;
  logic               out_valid_q;
  logic [dftd_pkg::RowIndexW-1:0] out_idx_q;
  logic [dftd_pkg::RowBitsW-1:0]  out_bits_q, row_bits;
  logic                           out_last_q;
  logic [RowW+dftd_pkg::RowIndexW-1:0] idx_ext;

  assign last_row = (row_q == RowW'(ROWS - 1));
  assign idx_ext  = {{dftd_pkg::RowIndexW{1'b0}}, row_q};

  // row cells fitted to the 26-bit field: zero fill or drop the excess
  always_comb begin
    for (int i = 0; i < dftd_pkg::RowBitsW; i++) begin
      if (i < COLUMNS) begin
        row_bits[i] = cells_q[row_q][i];
      end else begin
        row_bits[i] = 1'b0;
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    row_d     = row_q;
    cmd_pop_o = 1'b0;
    load      = 1'b0;
    toggle    = 1'b0;
    unique case (state_q)
      dftd_pkg::BK_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.kind == dftd_pkg::CMD_TOGGLE) begin
            cmd_pop_o = 1'b1;
            toggle    = 1'b1;
          end else begin
            state_d = dftd_pkg::BK_DUMP;
            row_d   = '0;
          end
        end
      end
      dftd_pkg::BK_DUMP: begin
        if (!out_valid_q || pop_i) begin
          load = 1'b1;
          if (last_row) begin
            cmd_pop_o = 1'b1;
            state_d   = dftd_pkg::BK_IDLE;
          end else begin
            row_d = row_q + 1'b1;
          end
        end
      end
      default: state_d = dftd_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dftd_pkg::BK_IDLE;
      row_q       <= '0;
      out_valid_q <= 1'b0;
      for (int r = 0; r < ROWS; r++) begin
        cells_q[r] <= '1;
      end
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
      if (toggle) begin
        cells_q[cmd_i.row[RowW-1:0]][cmd_i.col[ColW-1:0]] <=
          ~cells_q[cmd_i.row[RowW-1:0]][cmd_i.col[ColW-1:0]];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_idx_q  <= idx_ext[dftd_pkg::RowIndexW-1:0];
      out_bits_q <= row_bits;
      out_last_q <= last_row;
    end
  end

  assign empty_o      = !out_valid_q;
  assign row_index_o  = out_idx_q;
  assign row_bits_o   = out_bits_q;
  assign frame_last_o = out_last_q;

  // readout only runs with the frame command still at the queue head
  a_dump_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dftd_pkg::BK_DUMP) |-> (cmd_valid_i && cmd_i.kind == dftd_pkg::CMD_FRAME))
    else $error("readout without frame command at head");

  // a loaded row never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pop_i && state_q == dftd_pkg::BK_DUMP) |=> $stable(out_bits_q))
    else $error("waiting row overwritten");

  // no cell changes while a frame is being read out
  a_no_toggle_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dftd_pkg::BK_DUMP) |-> !toggle)
    else $error("toggle during readout");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dftd_pkg::BK_DUMP) |-> (row_q <= RowW'(ROWS - 1)))
    else $error("row counter out of range");

endmodule

// File: rtl/core/delta_frame_toggle_decoder.sv
// Channel  | Handshake          | Word
// ---------+--------------------+-------------------------------------------
// input    | push / full        | data_byte_i (column, row or frame marker)
// result   | pop / empty        | row_index_o, row_bits_o, frame_last_o
//
// Cycles: a byte is taken every cycle while the command queue has room; a
//   column byte alone or an off-grid pair leaves no command.
// A toggle lands in the bitmap at the edge that pops it from the queue head,
//   after its row byte has put it in the command queue; a frame marker is read
//   out one row per cycle into the output register while it is empty or popped.
// full rises when the two-entry command queue fills, e.g. while the back
//   end reads out a frame or waits on pop.
// Reset (rst_ni low, async): bitmap all black, column byte expected, queues
//   empty. No clearing pass is needed.
module delta_frame_toggle_decoder #(
  parameter int unsigned COLUMNS = dftd_pkg::DefColumns,
  parameter int unsigned ROWS    = dftd_pkg::DefRows
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic [7:0]                     data_byte_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [dftd_pkg::RowIndexW-1:0] row_index_o,
  output logic [dftd_pkg::RowBitsW-1:0]  row_bits_o,
  output logic                           frame_last_o
);

  logic           in_take;
  logic           cmd_push;
  dftd_pkg::cmd_t cmd_in, cmd_head;
  logic           cmd_valid, cmd_pop;

  // a byte is taken only when the queue can hold whatever it produces
  assign in_take = push && !full;

  // front: column/row pairing, marker detection, grid check
  dftd_front #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_take_i  (in_take),
    .data_byte_i(data_byte_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  // decouples byte intake from bitmap updates and frame readout
  dftd_cmd_fifo u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .wdata_i(cmd_in),
    .full_o (full),
    .pop_i  (cmd_pop),
    .valid_o(cmd_valid),
    .rdata_o(cmd_head)
  );

  // back: bitmap storage, toggles, row-by-row frame readout
  dftd_back #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .row_index_o (row_index_o),
    .row_bits_o  (row_bits_o),
    .frame_last_o(frame_last_o)
  );

endmodule

// File: dv/delta_frame_toggle_decoder_tb.sv
`timescale 1ns / 1ps

module delta_frame_toggle_decoder_tb;

  localparam int unsigned Cols = dftd_pkg::DefColumns;
  localparam int unsigned Rows = dftd_pkg::DefRows;
  localparam logic [dftd_pkg::RowBitsW-1:0] AllBlack = '1;
  // pop held low this many cycles so the command queue backs up into full
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned PhaseBytes = 82;

  // idle mix for both sides of the queue interface
  typedef enum int {
    PH_BUSY,
    PH_SEND_IDLE,
    PH_RECV_STALL,
    PH_BOTH
  } idle_phase_e;

  // one readout word as the back end should pop it
  typedef struct {
    logic [dftd_pkg::RowIndexW-1:0] idx;
    logic [dftd_pkg::RowBitsW-1:0]  bits;
    logic                           last;
  } row_word_t;

  // directed step: stream byte, plus a typed-in row value for frames whose
  // contents are obvious (all black right after reset or after undo)
  typedef struct packed {
    logic [7:0]                    b;
    logic                          typed;
    logic [dftd_pkg::RowBitsW-1:0] bits;
  } step_t;

  localparam int DirN = 23;
  localparam step_t DirectedSteps [DirN] = '{
    '{dftd_pkg::FrameMarker, 1'b1, AllBlack},  // readout straight out of reset
    '{8'd0,   1'b0, '0}, '{8'd0,   1'b0, '0},  // top-left corner
    '{8'd25,  1'b0, '0}, '{8'd8,   1'b0, '0},  // bottom-right corner
    '{8'd26,  1'b0, '0}, '{8'd0,   1'b0, '0},  // column just off the grid
    '{8'd0,   1'b0, '0}, '{8'd9,   1'b0, '0},  // row just off the grid
    '{8'd255, 1'b0, '0}, '{8'd255, 1'b0, '0},  // both bytes at max
    '{8'd5,   1'b0, '0}, '{dftd_pkg::FrameMarker, 1'b0, '0},  // marker value as row byte
    '{8'd49,  1'b0, '0}, '{8'd3,   1'b0, '0},
    '{8'd128, 1'b0, '0}, '{8'd127, 1'b0, '0},
    '{dftd_pkg::FrameMarker, 1'b0, '0},        // two corners flipped
    '{8'd0,   1'b0, '0}, '{8'd0,   1'b0, '0},
    '{8'd25,  1'b0, '0}, '{8'd8,   1'b0, '0},
    '{dftd_pkg::FrameMarker, 1'b1, AllBlack}   // corners flipped back
  };

  logic                           clk_i;
  logic                           rst_ni;
  logic                           push;
  logic                           full;
  logic [7:0]                     data_byte_i;
  logic                           empty;
  logic                           pop;
  logic [dftd_pkg::RowIndexW-1:0] row_index_o;
  logic [dftd_pkg::RowBitsW-1:0]  row_bits_o;
  logic                           frame_last_o;

  delta_frame_toggle_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .data_byte_i (data_byte_i),
    .empty       (empty),
    .pop         (pop),
    .row_index_o (row_index_o),
    .row_bits_o  (row_bits_o),
    .frame_last_o(frame_last_o)
  );

  // Shadow of the decoder: bitmap, parser state and the readout words owed.
  logic [dftd_pkg::RowBitsW-1:0] shadow_rows [Rows];
  logic                          want_row_byte;
  logic [7:0]                    held_column;
  row_word_t                     rows_due [$];

  idle_phase_e phase;
  bit          hold_req;
  int          bytes_sent;
  int          mismatches;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("[delta_frame_toggle_decoder] ERROR");
    $finish;
  end

  function automatic bit sender_rests();
    return (phase == PH_SEND_IDLE && $urandom_range(99) < 86) ||
           (phase == PH_BOTH && $urandom_range(99) < 15);
  endfunction

  function automatic bit receiver_rests();
    return (phase == PH_RECV_STALL && $urandom_range(99) < 86) ||
           (phase == PH_BOTH && $urandom_range(99) < 15);
  endfunction

  // Advance the shadow by one accepted byte. A frame marker in column
  // position owes one word per row; typed frames take the given row value.
  task automatic track_byte(input logic [7:0] b, input logic typed,
                            input logic [dftd_pkg::RowBitsW-1:0] typed_bits);
    row_word_t w;
    int r;
    begin
      if (want_row_byte) begin
        want_row_byte = 1'b0;
        // off-grid pairs are swallowed without touching the bitmap
        if (held_column < Cols && b < Rows)
          shadow_rows[b][held_column] = ~shadow_rows[b][held_column];
      end else if (b == dftd_pkg::FrameMarker) begin
        for (r = 0; r < Rows; r++) begin
          w.idx  = r[dftd_pkg::RowIndexW-1:0];
          w.bits = typed ? typed_bits : shadow_rows[r];
          w.last = (r == Rows - 1);
          rows_due.push_back(w);
        end
      end else begin
        held_column   = b;
        want_row_byte = 1'b1;
      end
    end
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic offer_byte(input logic [7:0] b, input logic typed,
                            input logic [dftd_pkg::RowBitsW-1:0] typed_bits);
    begin
      while (sender_rests()) begin
        push <= 1'b0;
        @(negedge clk_i);
      end
      push        <= 1'b1;
      data_byte_i <= b;
      do @(posedge clk_i); while (full);
      track_byte(b, typed, typed_bits);
      bytes_sent++;
      @(negedge clk_i);
    end
  endtask

  // Mostly well-formed in-grid pairs and frame markers; a share of single
  // random bytes knocks the column/row pairing out of step.
  task automatic random_command();
    int pick;
    begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        offer_byte(dftd_pkg::FrameMarker, 1'b0, '0);
      end else if (pick < 85) begin
        offer_byte(8'($urandom_range(Cols - 1)), 1'b0, '0);
        offer_byte(8'($urandom_range(Rows - 1)), 1'b0, '0);
      end else begin
        offer_byte(8'($urandom_range(255)), 1'b0, '0);
      end
    end
  endtask

  task automatic run_phase(input idle_phase_e p, input bit with_hold);
    int target;
    begin
      phase    = p;
      hold_req = with_hold;
      target   = bytes_sent + PhaseBytes;
      while (bytes_sent < target) random_command();
    end
  endtask

  task automatic check_row();
    row_word_t want;
    begin
      if (rows_due.size() == 0) begin
        mismatches++;
        $display("%0t: expected no word, actual row_index %0d row_bits %h frame_last %0d",
                 $time, row_index_o, row_bits_o, frame_last_o);
      end else begin
        want = rows_due.pop_front();
        if (row_index_o !== want.idx) begin
          mismatches++;
          $display("%0t: row_index expected %0d actual %0d",
                   $time, want.idx, row_index_o);
        end
        if (row_bits_o !== want.bits) begin
          mismatches++;
          $display("%0t: row_bits (row %0d) expected %h actual %h",
                   $time, want.idx, want.bits, row_bits_o);
        end
        if (frame_last_o !== want.last) begin
          mismatches++;
          $display("%0t: frame_last (row %0d) expected %0d actual %0d",
                   $time, want.idx, want.last, frame_last_o);
        end
      end
    end
  endtask

  // Result side: pop decided at the falling edge, word taken at the rising
  // edge. A hold request parks pop low for a fixed stretch so the sender
  // runs into full.
  initial begin
    int hold_left;
    hold_left = 0;
    pop       = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else begin
        pop <= !receiver_rests();
      end
      @(posedge clk_i);
      if (rst_ni && pop && !empty) check_row();
    end
  end

  // Stimulus: reset, directed walk, then random phases with varied idling.
  initial begin
    int k;
    int waited;
    rst_ni        = 1'b0;
    push          = 1'b0;
    data_byte_i   = '0;
    phase         = PH_BUSY;
    hold_req      = 1'b0;
    bytes_sent    = 0;
    mismatches    = 0;
    want_row_byte = 1'b0;
    held_column   = '0;
    for (k = 0; k < Rows; k++) shadow_rows[k] = AllBlack;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (k = 0; k < DirN; k++)
      offer_byte(DirectedSteps[k].b, DirectedSteps[k].typed, DirectedSteps[k].bits);

    run_phase(PH_BUSY, 1'b0);
    run_phase(PH_BUSY, 1'b1);
    run_phase(PH_SEND_IDLE, 1'b0);
    run_phase(PH_RECV_STALL, 1'b0);
    run_phase(PH_BOTH, 1'b0);

    // drain: let the receiver pop freely until every owed word is back
    push  <= 1'b0;
    phase = PH_BUSY;
    waited = 0;
    while (rows_due.size() != 0 && waited < 200_000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (30) @(posedge clk_i);

    if (mismatches == 0 && rows_due.size() == 0) begin
      $display("[delta_frame_toggle_decoder] OK");
    end else begin
      $display("[delta_frame_toggle_decoder] ERROR");
    end
    $finish;
  end

endmodule
